/* rtl/core/scanline_line_tracker_core_defines.svh */
// Assertion macros for the scan-row line tracker core.
// Included by RTL files that carry concurrent checks; expects clk and rst_n in scope.
`ifndef SCANLINE_LINE_TRACKER_CORE_DEFINES_SVH
`define SCANLINE_LINE_TRACKER_CORE_DEFINES_SVH
`ifndef SYNTHESIS
// Property must hold at every clock edge outside reset.
`define SLT_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("slt: assertion failed");
// Condition must never be true outside reset.
`define SLT_ASSERT_NEVER(lbl, cond) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
    else $error("slt: forbidden condition seen");
`else
`define SLT_ASSERT(lbl, prop)
`define SLT_ASSERT_NEVER(lbl, cond)
`endif
`endif

/* rtl/core/slt_pkg.sv */
// Shared types and constants for the scan-row line tracker core.
// No dependencies; imported by every module of the block.
package slt_pkg;

  // Default geometry
  localparam int ROW_WIDTH_DEF    = 640;
  localparam int MAX_SEGMENTS_DEF = 3;

  // Port widths
  localparam int IN_TDATA_W  = 24;
  localparam int OUT_TDATA_W = 24;
  localparam int CFG_ADDR_W  = 3;
  localparam int CFG_DATA_W  = 32;
  localparam int STEER_W     = 12;
  localparam int SEEK_W      = 2;
  localparam int LINES_W     = 2;
  localparam int RUN_W       = 8;
  localparam int TICK_W      = 32;

  // Register indexes
  typedef enum logic [CFG_ADDR_W-1:0] {
    CFG_HUE_LOW  = 3'd0,
    CFG_HUE_HIGH = 3'd1,
    CFG_SAT_LOW  = 3'd2,
    CFG_SAT_HIGH = 3'd3,
    CFG_VAL_LOW  = 3'd4,
    CFG_VAL_HIGH = 3'd5,
    CFG_MIN_RUN  = 3'd6,
    CFG_TIMEOUT  = 3'd7
  } cfg_idx_t;

  // Register reset values
  localparam logic [7:0]        HUE_LOW_RST  = 8'd21;
  localparam logic [7:0]        HUE_HIGH_RST = 8'd91;
  localparam logic [7:0]        SAT_LOW_RST  = 8'd40;
  localparam logic [7:0]        SAT_HIGH_RST = 8'd255;
  localparam logic [7:0]        VAL_LOW_RST  = 8'd0;
  localparam logic [7:0]        VAL_HIGH_RST = 8'd255;
  localparam logic [RUN_W-1:0]  MIN_RUN_RST  = 8'd25;
  localparam logic [TICK_W-1:0] TIMEOUT_RST  = 32'd13000;

  // Search side codes
  localparam logic [SEEK_W-1:0] SEEK_NONE  = 2'd0;
  localparam logic [SEEK_W-1:0] SEEK_LEFT  = 2'd1;
  localparam logic [SEEK_W-1:0] SEEK_RIGHT = 2'd2;

  typedef struct packed {
    logic [7:0]        hue_low;
    logic [7:0]        hue_high;
    logic [7:0]        sat_low;
    logic [7:0]        sat_high;
    logic [7:0]        val_low;
    logic [7:0]        val_high;
    logic [RUN_W-1:0]  min_run;
    logic [TICK_W-1:0] timeout_ticks;
  } cfg_t;

  // Request held in the input register
  typedef struct packed {
    logic tick;
    logic bg;
    logic row_end;
  } px_item_t;

  // Result record, steer position in the low bits
  typedef struct packed {
    logic [LINES_W-1:0] lines_found;
    logic [SEEK_W-1:0]  seek_side;
    logic               line_lost;
    logic [STEER_W-1:0] steer_position;
  } res_t;

endpackage

/* rtl/core/slt_classify.sv */
// Input register and HSV window classifier of the line tracker.
// Depends on slt_pkg.
module slt_classify
  import slt_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  cfg_t                  cfg,
  input  logic                  in_tvalid,
  output logic                  in_tready,
  input  logic [IN_TDATA_W-1:0] in_tdata,
  input  logic                  in_tuser,
  input  logic                  in_tlast,
  input  logic                  adv,
  output logic                  s1_valid,
  output px_item_t              s1_item
);

  logic     valid_r, valid_nxt;
  px_item_t item_r;
  logic [7:0] hue, sat, val;
  logic       bg;

  assign hue = in_tdata[7:0];
  assign sat = in_tdata[15:8];
  assign val = in_tdata[23:16];

  // Background when all three channels sit inside their windows
  assign bg = (hue >= cfg.hue_low) && (hue <= cfg.hue_high) &&
              (sat >= cfg.sat_low) && (sat <= cfg.sat_high) &&
              (val >= cfg.val_low) && (val <= cfg.val_high);

  // Take a new request when the register is empty or drains this cycle
  assign in_tready = !valid_r || adv;

  always_comb begin
    valid_nxt = valid_r;
    if (in_tready) begin
      valid_nxt = in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tready && in_tvalid) begin
      item_r.tick    <= in_tuser;
      item_r.bg      <= bg;
      item_r.row_end <= in_tlast;
    end
  end

  assign s1_valid = valid_r;
  assign s1_item  = item_r;

endmodule

/* rtl/core/slt_segment.sv */
// Row segment finder: run counters, segment starts and stops, midpoints at row end.
// Depends on slt_pkg.
module slt_segment
  import slt_pkg::*;
#(
  parameter int ROW_WIDTH    = ROW_WIDTH_DEF,
  parameter int MAX_SEGMENTS = MAX_SEGMENTS_DEF,
  parameter int COL_W        = $clog2(ROW_WIDTH + 1),
  parameter int CNT_W        = $clog2(MAX_SEGMENTS + 1)
)
(
  input  logic             clk,
  input  logic             rst_n,
  input  logic             px_proc,
  input  logic             bg,
  input  logic             row_end,
  input  logic [RUN_W-1:0] min_run,
  output logic [COL_W-1:0] mid0,
  output logic [COL_W-1:0] mid1,
  output logic [CNT_W-1:0] seg_count
);

  localparam logic [COL_W-1:0] ROW_END_COL = COL_W'(ROW_WIDTH);
  localparam logic [CNT_W-1:0] SEG_LIMIT   = CNT_W'(MAX_SEGMENTS);
  localparam logic [CNT_W-1:0] TRACKED     = CNT_W'(2);

  logic [COL_W-1:0] col_r, col_nxt;
  logic             in_seg_r, in_seg_nxt;
  logic [RUN_W-1:0] light_r, light_nxt;
  logic [RUN_W-1:0] dark_r, dark_nxt;
  logic [CNT_W-1:0] start_cnt_r, start_cnt_nxt;
  logic [CNT_W-1:0] stop_cnt_r, stop_cnt_nxt;
  // Only the first two segments feed steering
  logic [COL_W-1:0] start_pos_r [2];
  logic [COL_W-1:0] start_pos_nxt [2];
  logic [COL_W-1:0] stop_pos_r [2];
  logic [COL_W-1:0] stop_pos_nxt [2];
  logic [COL_W-1:0] stop_fin [2];
  logic [COL_W-1:0] mid [2];
  logic [COL_W:0]   pos_sum [2];
  logic [RUN_W-1:0] run;

  assign run = (min_run == '0) ? RUN_W'(1) : min_run;

  // Advance run counters for one pixel
  always_comb begin
    col_nxt       = col_r;
    in_seg_nxt    = in_seg_r;
    light_nxt     = light_r;
    dark_nxt      = dark_r;
    start_cnt_nxt = start_cnt_r;
    stop_cnt_nxt  = stop_cnt_r;
    start_pos_nxt = start_pos_r;
    stop_pos_nxt  = stop_pos_r;
    if (col_r < ROW_END_COL) begin
      if (start_cnt_r < SEG_LIMIT) begin
        if (!in_seg_r) begin
          if (!bg) begin
            light_nxt = light_r + RUN_W'(1);
            if (light_r == '0 && start_cnt_r < TRACKED) begin
              start_pos_nxt[start_cnt_r[0]] = col_r;
            end
          end else begin
            light_nxt = '0;
            if (start_cnt_r < TRACKED) begin
              start_pos_nxt[start_cnt_r[0]] = '0;
            end
          end
          if (light_nxt == run) begin
            start_cnt_nxt = start_cnt_r + CNT_W'(1);
            light_nxt     = '0;
            in_seg_nxt    = 1'b1;
          end
        end else if (stop_cnt_r < SEG_LIMIT) begin
          if (bg) begin
            dark_nxt = dark_r + RUN_W'(1);
            if (dark_r == '0 && stop_cnt_r < TRACKED) begin
              stop_pos_nxt[stop_cnt_r[0]] = col_r;
            end
          end else begin
            dark_nxt = '0;
            if (stop_cnt_r < TRACKED) begin
              stop_pos_nxt[stop_cnt_r[0]] = '0;
            end
          end
          if (dark_nxt == run) begin
            stop_cnt_nxt = stop_cnt_r + CNT_W'(1);
            dark_nxt     = '0;
            in_seg_nxt   = 1'b0;
          end
        end
      end
      col_nxt = col_r + COL_W'(1);
    end
  end

  // Close an open segment at the row width and take midpoints
  always_comb begin
    for (int k = 0; k < 2; k++) begin
      if (in_seg_nxt && stop_cnt_nxt == CNT_W'(k)) begin
        stop_fin[k] = col_nxt;
      end else begin
        stop_fin[k] = stop_pos_nxt[k];
      end
      pos_sum[k] = {1'b0, start_pos_nxt[k]} + {1'b0, stop_fin[k]};
      if (start_cnt_nxt > CNT_W'(k)) begin
        mid[k] = pos_sum[k][COL_W:1];
      end else begin
        mid[k] = '0;
      end
    end
  end

  assign mid0      = mid[0];
  assign mid1      = mid[1];
  assign seg_count = start_cnt_nxt;

  // Hold row counters; clear them after the row's last pixel
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r       <= '0;
      in_seg_r    <= 1'b0;
      light_r     <= '0;
      dark_r      <= '0;
      start_cnt_r <= '0;
      stop_cnt_r  <= '0;
    end else if (px_proc) begin
      if (row_end) begin
        col_r       <= '0;
        in_seg_r    <= 1'b0;
        light_r     <= '0;
        dark_r      <= '0;
        start_cnt_r <= '0;
        stop_cnt_r  <= '0;
      end else begin
        col_r       <= col_nxt;
        in_seg_r    <= in_seg_nxt;
        light_r     <= light_nxt;
        dark_r      <= dark_nxt;
        start_cnt_r <= start_cnt_nxt;
        stop_cnt_r  <= stop_cnt_nxt;
      end
    end
  end

  // Positions are always rewritten before they are read
  always_ff @(posedge clk) begin
    if (px_proc) begin
      start_pos_r <= start_pos_nxt;
      stop_pos_r  <= row_end ? stop_fin : stop_pos_nxt;
    end
  end

endmodule

/* rtl/core/slt_steer.sv */
// Steering decision, lost and search flags, tick timer of the line tracker.
// Depends on slt_pkg; fed by slt_segment.
module slt_steer
  import slt_pkg::*;
#(
  parameter int ROW_WIDTH    = ROW_WIDTH_DEF,
  parameter int MAX_SEGMENTS = MAX_SEGMENTS_DEF,
  parameter int COL_W        = $clog2(ROW_WIDTH + 1),
  parameter int CNT_W        = $clog2(MAX_SEGMENTS + 1)
)
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              tick_proc,
  input  logic              row_proc,
  input  logic [TICK_W-1:0] timeout_ticks,
  input  logic [COL_W-1:0]  mid0,
  input  logic [COL_W-1:0]  mid1,
  input  logic [CNT_W-1:0]  seg_count,
  output res_t              result
);

  localparam logic [COL_W-1:0] STEER_RIGHT = COL_W'(ROW_WIDTH);
  localparam logic [COL_W-1:0] STEER_MID   = COL_W'(ROW_WIDTH / 2);

  logic [COL_W-1:0]  pm0_r, pm1_r;
  logic [COL_W-1:0]  last_r, last_nxt;
  logic              sl_r, sl_nxt;
  logic              sr_r, sr_nxt;
  logic              lost_r, lost_nxt;
  logic [TICK_W-1:0] el_r, el_nxt;
  logic              right_seen, left_seen, pm0_set;
  logic [COL_W-1:0]  dist0, dist1;

  assign pm0_set    = (pm0_r != '0);
  assign right_seen = (pm1_r > last_r) && pm0_set;
  assign left_seen  = (last_r > pm0_r) && pm0_set;
  assign dist0      = (mid0 > last_r) ? (mid0 - last_r) : (last_r - mid0);
  assign dist1      = (mid1 > last_r) ? (mid1 - last_r) : (last_r - mid1);

  // Row-end flag update, applied in order
  always_comb begin
    sl_nxt   = sl_r;
    sr_nxt   = sr_r;
    lost_nxt = lost_r;
    el_nxt   = el_r;
    if (right_seen && !lost_r && !sr_nxt) begin
      el_nxt = '0;
      sl_nxt = 1'b0;
      sr_nxt = 1'b1;
    end
    if (left_seen && !lost_r && !sl_nxt) begin
      el_nxt = '0;
      sr_nxt = 1'b0;
      sl_nxt = 1'b1;
    end
    if (lost_r && pm0_set) begin
      sl_nxt = 1'b0;
      sr_nxt = 1'b0;
    end
    if (el_nxt > timeout_ticks && !lost_r) begin
      sl_nxt = 1'b0;
      sr_nxt = 1'b0;
      el_nxt = '0;
    end
    if (pm0_set && lost_r) begin
      lost_nxt = 1'b0;
      el_nxt   = '0;
    end
    if (mid0 == '0 && !lost_nxt) begin
      lost_nxt = 1'b1;
    end
    // Pick the steering column
    if (lost_nxt) begin
      if (sr_nxt) begin
        last_nxt = STEER_RIGHT;
      end else if (sl_nxt) begin
        last_nxt = '0;
      end else begin
        last_nxt = STEER_MID;
      end
    end else if (seg_count > CNT_W'(1)) begin
      last_nxt = (dist0 < dist1) ? mid0 : mid1;
    end else begin
      last_nxt = mid0;
    end
  end

  always_comb begin
    result.steer_position = STEER_W'(last_nxt);
    result.line_lost      = lost_nxt;
    result.seek_side      = sr_nxt ? SEEK_RIGHT : (sl_nxt ? SEEK_LEFT : SEEK_NONE);
    result.lines_found    = seg_count[LINES_W-1:0];
  end

  // Commit flags on row end, count ticks up to saturation
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pm0_r  <= '0;
      pm1_r  <= '0;
      last_r <= '0;
      sl_r   <= 1'b0;
      sr_r   <= 1'b0;
      lost_r <= 1'b0;
      el_r   <= '1;
    end else if (row_proc) begin
      pm0_r  <= mid0;
      pm1_r  <= mid1;
      last_r <= last_nxt;
      sl_r   <= sl_nxt;
      sr_r   <= sr_nxt;
      lost_r <= lost_nxt;
      el_r   <= el_nxt;
    end else if (tick_proc && el_r != '1) begin
      el_r <= el_r + TICK_W'(1);
    end
  end

endmodule

/* rtl/core/scanline_line_tracker_core.sv */
// Scan-row line tracker core, top level.
// Depends on slt_pkg, slt_classify, slt_segment, slt_steer and the defines header.
//
// Usage: HSV pixels of one scan row arrive left to right on the in_ stream, one
// request per pixel (in_tuser = 0) with in_tlast on the row's last pixel; a
// request with in_tuser = 1 is a timer tick and carries no pixel. Each row's
// last pixel yields exactly one result on the out_ stream; other requests yield
// none. The cfg_ port writes the window, run length and timeout registers; write
// only while no request is in flight.
// Throughput: one request per cycle unless stalled as below. A row's last pixel
// passes the input register, then the result register, before its result shows
// on out_tvalid. All per-pixel work sits between those two registers.
// Stall: a result waits in the result register while out_tready is low; pixels
// and ticks keep flowing until a further row end meets the full register, and
// only then in_tready drops.
// Reset (rst_n low, synchronous): row counters, flags and steering clear, the
// tick timer saturates at all ones, registers take their reset values.
`include "scanline_line_tracker_core_defines.svh"
module scanline_line_tracker_core
  import slt_pkg::*;
#(
  parameter int ROW_WIDTH    = ROW_WIDTH_DEF,
  parameter int MAX_SEGMENTS = MAX_SEGMENTS_DEF
)
(
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_tvalid,
  output logic                   in_tready,
  input  logic [IN_TDATA_W-1:0]  in_tdata,   // pixel_hue[7:0], pixel_sat[15:8], pixel_val[23:16]
  input  logic                   in_tuser,   // req_type
  input  logic                   in_tlast,   // row_end
  output logic                   out_tvalid,
  input  logic                   out_tready,
  // steer_position[11:0], line_lost[12], seek_side[14:13], lines_found[16:15], zeros above
  output logic [OUT_TDATA_W-1:0] out_tdata,
  input  logic                   cfg_we,
  input  logic [CFG_ADDR_W-1:0]  cfg_addr,
  input  logic [CFG_DATA_W-1:0]  cfg_wdata
);

  localparam int COL_W = $clog2(ROW_WIDTH + 1);
  localparam int CNT_W = $clog2(MAX_SEGMENTS + 1);

  cfg_t             cfg_r;
  logic             s1_valid;
  px_item_t         s1_item;
  logic             needs_out, out_free, adv;
  logic             px_proc, tick_proc, row_proc;
  logic [COL_W-1:0] mid0, mid1;
  logic [CNT_W-1:0] seg_count;
  res_t             res;
  logic             out_valid_r;
  res_t             out_res_r;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.hue_low       <= HUE_LOW_RST;
      cfg_r.hue_high      <= HUE_HIGH_RST;
      cfg_r.sat_low       <= SAT_LOW_RST;
      cfg_r.sat_high      <= SAT_HIGH_RST;
      cfg_r.val_low       <= VAL_LOW_RST;
      cfg_r.val_high      <= VAL_HIGH_RST;
      cfg_r.min_run       <= MIN_RUN_RST;
      cfg_r.timeout_ticks <= TIMEOUT_RST;
    end else if (cfg_we) begin
      unique case (cfg_idx_t'(cfg_addr))
        CFG_HUE_LOW:  cfg_r.hue_low       <= cfg_wdata[7:0];
        CFG_HUE_HIGH: cfg_r.hue_high      <= cfg_wdata[7:0];
        CFG_SAT_LOW:  cfg_r.sat_low       <= cfg_wdata[7:0];
        CFG_SAT_HIGH: cfg_r.sat_high      <= cfg_wdata[7:0];
        CFG_VAL_LOW:  cfg_r.val_low       <= cfg_wdata[7:0];
        CFG_VAL_HIGH: cfg_r.val_high      <= cfg_wdata[7:0];
        CFG_MIN_RUN:  cfg_r.min_run       <= cfg_wdata[RUN_W-1:0];
        CFG_TIMEOUT:  cfg_r.timeout_ticks <= cfg_wdata[TICK_W-1:0];
        default:      cfg_r               <= cfg_r;
      endcase
    end
  end

  slt_classify u_classify (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg_r),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .in_tlast  (in_tlast),
    .adv       (adv),
    .s1_valid  (s1_valid),
    .s1_item   (s1_item)
  );

  // Process the held request unless it is a row end facing a full result register
  assign needs_out = s1_item.row_end && !s1_item.tick;
  assign out_free  = !out_valid_r || out_tready;
  assign adv       = s1_valid && (!needs_out || out_free);
  assign px_proc   = adv && !s1_item.tick;
  assign tick_proc = adv && s1_item.tick;
  assign row_proc  = px_proc && s1_item.row_end;

  slt_segment #(
    .ROW_WIDTH    (ROW_WIDTH),
    .MAX_SEGMENTS (MAX_SEGMENTS),
    .COL_W        (COL_W),
    .CNT_W        (CNT_W)
  ) u_segment (
    .clk       (clk),
    .rst_n     (rst_n),
    .px_proc   (px_proc),
    .bg        (s1_item.bg),
    .row_end   (s1_item.row_end),
    .min_run   (cfg_r.min_run),
    .mid0      (mid0),
    .mid1      (mid1),
    .seg_count (seg_count)
  );

  slt_steer #(
    .ROW_WIDTH    (ROW_WIDTH),
    .MAX_SEGMENTS (MAX_SEGMENTS),
    .COL_W        (COL_W),
    .CNT_W        (CNT_W)
  ) u_steer (
    .clk           (clk),
    .rst_n         (rst_n),
    .tick_proc     (tick_proc),
    .row_proc      (row_proc),
    .timeout_ticks (cfg_r.timeout_ticks),
    .mid0          (mid0),
    .mid1          (mid1),
    .seg_count     (seg_count),
    .result        (res)
  );

  // Result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (row_proc) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (row_proc) begin
      out_res_r <= res;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = OUT_TDATA_W'(out_res_r);

  `SLT_ASSERT_NEVER(a_out_overrun, row_proc && out_valid_r && !out_tready)
  `SLT_ASSERT(a_row_end_shows, row_proc |=> out_valid_r)
  `SLT_ASSERT(a_stall_has_item, !in_tready |-> s1_valid && needs_out)
  `SLT_ASSERT(a_seek_code, out_valid_r |-> out_res_r.seek_side != (SEEK_LEFT | SEEK_RIGHT))
  `SLT_ASSERT(a_lost_right, out_valid_r && out_res_r.line_lost && out_res_r.seek_side == SEEK_RIGHT |-> out_res_r.steer_position == STEER_W'(ROW_WIDTH))

endmodule
